FILE: design/irdf_pkg.sv
// Shared types, constants and the sensor angle table of the IR ring direction finder.
`default_nettype none
package irdf_pkg;
    localparam int Sensors = 16;
    localparam int CountBits = 16;
    localparam int IdxBits = $clog2(Sensors);
    localparam int RespBits = $clog2(Sensors + 1);
    localparam int LimitBits = 5;
    localparam int CfgIndexBits = 8;
    localparam int AngleBits = 16;

    typedef logic [CountBits-1:0] count_t;
    typedef logic [IdxBits-1:0] idx_t;
    typedef logic [RespBits-1:0] resp_t;
    typedef logic [LimitBits-1:0] limit_t;
    typedef logic [CfgIndexBits-1:0] cfg_index_t;
    typedef logic signed [AngleBits-1:0] angle_t;

    typedef enum logic [CfgIndexBits-1:0] {
        REG_FAR_LIMIT    = 8'd0,
        REG_MIDDLE_LIMIT = 8'd1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        DIST_FAR    = 2'd0,
        DIST_MIDDLE = 2'd1,
        DIST_NEAR   = 2'd2
    } dist_t;

    localparam limit_t FarLimitReset = 5'd3;
    localparam limit_t MiddleLimitReset = 5'd8;
    localparam angle_t BackAngle = 16'sd18000;
    localparam idx_t BackLeftIdx = 4'd7;
    localparam idx_t BackRightIdx = 4'd8;

    function automatic angle_t angle_of(input idx_t i);
        angle_t a;
        case (i)
            4'd0:    a = 16'sd1125;
            4'd1:    a = 16'sd3375;
            4'd2:    a = 16'sd5625;
            4'd3:    a = 16'sd7875;
            4'd4:    a = 16'sd10125;
            4'd5:    a = 16'sd12375;
            4'd6:    a = 16'sd14625;
            4'd7:    a = 16'sd16875;
            4'd8:    a = -16'sd16875;
            4'd9:    a = -16'sd14625;
            4'd10:   a = -16'sd12375;
            4'd11:   a = -16'sd10125;
            4'd12:   a = -16'sd7875;
            4'd13:   a = -16'sd5625;
            4'd14:   a = -16'sd3375;
            default: a = -16'sd1125;
        endcase
        return a;
    endfunction
endpackage
`default_nettype wire

FILE: design/ir_ring_direction_finder.sv
// Top level: hit counters, sequential scan and result register of the IR ring direction finder.
`default_nettype none
// Each pin sample beat taken while idle bumps the saturating hit counter
// of every sensor that sees light. A beat marked window_end also starts a
// scan that walks the 16 counters one per cycle through a single compare
// unit; a finish state then forms direction and distance and clears the
// counters, waiting there while the previous result has not yet been taken,
// before the next sample is taken. in_stall is high during the scan and the
// finish state. Configuration writes are taken at any time (cfg_ready
// stays high); indexes other than 0 and 1 are ignored.
module ir_ring_direction_finder (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [15:0]                 pin_levels,
    input  wire logic                        window_end,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic                             ball_seen,
    output logic signed [15:0]               direction_centideg,
    output logic [1:0]                       distance_class,
    output logic [4:0]                       responders,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire irdf_pkg::cfg_index_t        cfg_index,
    input  wire irdf_pkg::limit_t            cfg_data
);
    import irdf_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    count_t counts_reg [Sensors];
    idx_t   idx_reg, idx_next;
    count_t best_reg, best_next;
    resp_t  resp_reg, resp_next;
    idx_t   first_reg, first_next;
    idx_t   tie_reg, tie_next;
    logic   has_tie_reg, has_tie_next;
    limit_t far_limit_reg, middle_limit_reg;

    logic   out_valid_reg, out_valid_next;
    logic   ball_seen_reg, ball_seen_next;
    angle_t dir_reg, dir_next;
    dist_t  dist_reg, dist_next;
    resp_t  resp_out_reg, resp_out_next;

    logic   in_take;
    logic   clear_counts;
    count_t cur;
    angle_t ang_first, ang_tie;
    logic signed [AngleBits:0] ang_sum, ang_half;

    assign in_take   = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign cur       = counts_reg[idx_reg];
    assign ang_first = angle_of(first_reg);
    assign ang_tie   = angle_of(tie_reg);
    assign ang_sum   = {ang_first[AngleBits-1], ang_first} + {ang_tie[AngleBits-1], ang_tie};
    assign ang_half  = (ang_sum + {{AngleBits{1'b0}}, ang_sum[AngleBits]}) >>> 1;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        best_next      = best_reg;
        resp_next      = resp_reg;
        first_next     = first_reg;
        tie_next       = tie_reg;
        has_tie_next   = has_tie_reg;
        out_valid_next = out_valid_reg && out_stall;
        ball_seen_next = ball_seen_reg;
        dir_next       = dir_reg;
        dist_next      = dist_reg;
        resp_out_next  = resp_out_reg;
        clear_counts   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take && window_end)
                begin
                    state_next   = ST_SCAN;
                    idx_next     = '0;
                    best_next    = '0;
                    resp_next    = '0;
                    first_next   = '0;
                    tie_next     = '0;
                    has_tie_next = 1'b0;
                end
            end
            ST_SCAN:
            begin
                if (cur != '0)
                begin
                    resp_next = resp_reg + resp_t'(1);
                    if (cur > best_reg)
                    begin
                        best_next    = cur;
                        first_next   = idx_reg;
                        has_tie_next = 1'b0;
                    end
                    else if (cur == best_reg)
                    begin
                        tie_next     = idx_reg;
                        has_tie_next = 1'b1;
                    end
                end
                idx_next = idx_reg + idx_t'(1);
                if (idx_reg == idx_t'(Sensors - 1))
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    clear_counts   = 1'b1;
                    out_valid_next = 1'b1;
                    ball_seen_next = (best_reg != '0);
                    resp_out_next  = resp_reg;
                    if (best_reg == '0)
                    begin
                        dir_next  = '0;
                        dist_next = DIST_FAR;
                    end
                    else
                    begin
                        if (resp_reg <= far_limit_reg)
                            dist_next = DIST_FAR;
                        else if (resp_reg <= middle_limit_reg)
                            dist_next = DIST_MIDDLE;
                        else
                            dist_next = DIST_NEAR;
                        if (!has_tie_reg)
                            dir_next = ang_first;
                        else if (first_reg == BackLeftIdx && tie_reg == BackRightIdx)
                            dir_next = BackAngle;
                        else
                            dir_next = ang_half[AngleBits-1:0];
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            best_reg      <= '0;
            resp_reg      <= '0;
            first_reg     <= '0;
            tie_reg       <= '0;
            has_tie_reg   <= 1'b0;
            ball_seen_reg <= 1'b0;
            dir_reg       <= '0;
            dist_reg      <= DIST_FAR;
            resp_out_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
            best_reg      <= best_next;
            resp_reg      <= resp_next;
            first_reg     <= first_next;
            tie_reg       <= tie_next;
            has_tie_reg   <= has_tie_next;
            ball_seen_reg <= ball_seen_next;
            dir_reg       <= dir_next;
            dist_reg      <= dist_next;
            resp_out_reg  <= resp_out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < Sensors; i++)
                counts_reg[i] <= '0;
        end
        else if (clear_counts)
        begin
            for (int i = 0; i < Sensors; i++)
                counts_reg[i] <= '0;
        end
        else if (in_take)
        begin
            for (int i = 0; i < Sensors; i++)
            begin
                if (!pin_levels[i] && counts_reg[i] != '1)
                    counts_reg[i] <= counts_reg[i] + count_t'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            far_limit_reg    <= FarLimitReset;
            middle_limit_reg <= MiddleLimitReset;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_FAR_LIMIT:    far_limit_reg <= cfg_data;
                REG_MIDDLE_LIMIT: middle_limit_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign out_valid          = out_valid_reg;
    assign ball_seen          = ball_seen_reg;
    assign direction_centideg = dir_reg;
    assign distance_class     = dist_reg;
    assign responders         = resp_out_reg;

    a_seen_matches_resp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (ball_seen == (responders != '0)))
        else $error("ball_seen disagrees with responders");

    a_no_ball_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !ball_seen) |-> (direction_centideg == '0 && distance_class == DIST_FAR))
        else $error("no-ball result carries direction or distance");

    a_end_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && window_end) |=> in_stall)
        else $error("window end beat did not start the scan");

    a_dist_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (distance_class != 2'd3))
        else $error("distance class out of range");
endmodule
`default_nettype wire
